### rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared constants for the byte stream lexer: default counter widths, token
// kinds, result queue depth and the single-character token decoder.
// ----------------------------------------------------------------------------
package bsl_pkg;

   localparam int LINE_BITS_DEFAULT   = 20;
   localparam int COLUMN_BITS_DEFAULT = 16;
   localparam int LENGTH_BITS_DEFAULT = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int KIND_BITS   = 5;

   localparam logic [KIND_BITS-1:0] KIND_EOF       = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_ADD       = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_SUB       = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_MUL       = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_DIV       = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_EQ        = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN    = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_LT        = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_GT        = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_COMMA     = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_IDENT     = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_DEF       = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_VAL       = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_IF        = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_ELSE      = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_ERROR     = 5'd21;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;

   localparam logic [31:0] WORD_DEF  = 32'h0064_6566;
   localparam logic [31:0] WORD_VAL  = 32'h0076_616C;
   localparam logic [31:0] WORD_IF   = 32'h0000_6966;
   localparam logic [31:0] WORD_ELSE = 32'h656C_7365;

   // EOF code doubles as "not a single-character token"
   function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] b);
      case (b)
         8'h2B:   single_kind = KIND_ADD;
         8'h2D:   single_kind = KIND_SUB;
         8'h2A:   single_kind = KIND_MUL;
         8'h3C:   single_kind = KIND_LT;
         8'h3E:   single_kind = KIND_GT;
         8'h28:   single_kind = KIND_LPAREN;
         8'h29:   single_kind = KIND_RPAREN;
         8'h7B:   single_kind = KIND_LBRACE;
         8'h7D:   single_kind = KIND_RBRACE;
         8'h2C:   single_kind = KIND_COMMA;
         8'h3B:   single_kind = KIND_SEMICOLON;
         default: single_kind = KIND_EOF;
      endcase
   endfunction

endpackage

### rtl/bsl_result_queue.sv
// ----------------------------------------------------------------------------
// bsl_result_queue
// Small result queue: takes up to two words per cycle, delivers one per
// cycle while out_ready is high, and reports room for two more words.
// ----------------------------------------------------------------------------
module bsl_result_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push0_valid,
   input  logic [WIDTH-1:0] push0_data,
   input  logic             push1_valid,
   input  logic [WIDTH-1:0] push1_data,
   output logic             room_two,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int DEPTH = bsl_pkg::QUEUE_DEPTH;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] tail0, tail1;
   logic             pop;

   assign tail0     = head_ff + count_ff[IDX_W-1:0];
   assign tail1     = tail0 + IDX_W'(1);
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[head_ff];
   assign pop       = out_valid && out_ready;
   assign room_two  = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      count_in = count_ff + CNT_W'(push0_valid) + CNT_W'(push1_valid) - CNT_W'(pop);
      head_in  = pop ? head_ff + IDX_W'(1) : head_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0_valid) begin
         slot_ff[tail0] <= push0_data;
      end
      if (push1_valid) begin
         slot_ff[tail1] <= push1_data;
      end
   end

endmodule

### rtl/byte_stream_lexer.sv
// ----------------------------------------------------------------------------
// byte_stream_lexer
// Streaming lexer: one source byte per word in, tokens with positions out.
// ----------------------------------------------------------------------------
// A token is pushed into the result queue when the byte that ends it is
// accepted, and is offered on rsp from the queue's registered slots. One byte
// per cycle while two queue entries are free; a byte that ends two tokens
// pushes both into the 4-word result queue, which feeds the single rsp port.
// Reset: line and column go to 1, offset to 0, scanner idle, queue empty.
// ----------------------------------------------------------------------------
module byte_stream_lexer #(
   parameter int LINE_BITS   = bsl_pkg::LINE_BITS_DEFAULT,
   parameter int COLUMN_BITS = bsl_pkg::COLUMN_BITS_DEFAULT,
   parameter int LENGTH_BITS = bsl_pkg::LENGTH_BITS_DEFAULT,
   localparam int RSP_BITS   = 2 * LINE_BITS + 2 * COLUMN_BITS + 32 + LENGTH_BITS,
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // data_byte
   input  logic                          req_tuser,  // is_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // begin_line, begin_column, end_line, end_column, start_offset, token_length
   output logic [RSP_DATA_W-1:0]         rsp_tdata,
   output logic [bsl_pkg::KIND_BITS-1:0] rsp_tuser,  // token_kind
   output logic                          rsp_tlast   // last_of_run
);

   localparam int KB      = bsl_pkg::KIND_BITS;
   localparam int ENTRY_W = 1 + KB + RSP_BITS;

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_EQ1     = 3'd2;
   localparam logic [2:0] MODE_NUMBER  = 3'd3;
   localparam logic [2:0] MODE_IDENT   = 3'd4;
   localparam logic [2:0] MODE_COMMENT = 3'd5;
   localparam logic [2:0] MODE_ERRORED = 3'd6;

   logic [2:0]             mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, pbl_ff, pbl_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, pbc_ff, pbc_in;
   logic [31:0]            off_ff, off_in, pbo_ff, pbo_in;
   logic [LENGTH_BITS-1:0] plen_ff, plen_in;
   logic [31:0]            prefix_ff, prefix_in;

   logic [7:0]             b;
   logic                   accept, is_end;
   logic                   is_ws, is_digit, is_letter, is_identc;
   logic [KB-1:0]          one_kind, flush_kind, ident_kind;
   logic                   has_pending, do_idle;
   logic [LINE_BITS-1:0]   adv_line;
   logic [COLUMN_BITS-1:0] adv_col;
   logic [31:0]            adv_off;
   logic [LENGTH_BITS-1:0] len_plus;

   logic                   r0_valid, r1_valid;
   logic [KB-1:0]          r0_kind, r1_kind;
   logic [LINE_BITS-1:0]   r1_bl, r1_el;
   logic [COLUMN_BITS-1:0] r1_bc, r1_ec;
   logic [31:0]            r1_off;
   logic [LENGTH_BITS-1:0] r1_len;
   logic [RSP_BITS-1:0]    r0_bits, r1_bits;
   logic                   p0_valid, p1_valid;
   logic [ENTRY_W-1:0]     p0_data, p1_data, q_data;

   assign b         = req_tdata;
   assign accept    = req_tvalid && req_tready;
   assign is_end    = req_tuser || (b == bsl_pkg::CHAR_NUL);
   assign is_ws     = (b == bsl_pkg::CHAR_SPACE) || (b == bsl_pkg::CHAR_TAB) ||
                      (b == bsl_pkg::CHAR_CR) || (b == bsl_pkg::CHAR_LF);
   assign is_digit  = (b >= 8'h30) && (b <= 8'h39);
   assign is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   assign is_identc = is_digit || is_letter || (b == bsl_pkg::CHAR_UNDER);
   assign one_kind  = bsl_pkg::single_kind(b);

   always_comb begin
      if (b == bsl_pkg::CHAR_LF) begin
         adv_line = (line_ff != '1) ? line_ff + LINE_BITS'(1) : line_ff;
         adv_col  = COLUMN_BITS'(1);
      end else begin
         adv_line = line_ff;
         adv_col  = (col_ff != '1) ? col_ff + COLUMN_BITS'(1) : col_ff;
      end
      adv_off  = (off_ff != '1) ? off_ff + 32'd1 : off_ff;
      len_plus = (plen_ff != '1) ? plen_ff + LENGTH_BITS'(1) : plen_ff;
   end

   always_comb begin
      if (plen_ff == LENGTH_BITS'(3) && prefix_ff == bsl_pkg::WORD_DEF) begin
         ident_kind = bsl_pkg::KIND_DEF;
      end else if (plen_ff == LENGTH_BITS'(3) && prefix_ff == bsl_pkg::WORD_VAL) begin
         ident_kind = bsl_pkg::KIND_VAL;
      end else if (plen_ff == LENGTH_BITS'(2) && prefix_ff == bsl_pkg::WORD_IF) begin
         ident_kind = bsl_pkg::KIND_IF;
      end else if (plen_ff == LENGTH_BITS'(4) && prefix_ff == bsl_pkg::WORD_ELSE) begin
         ident_kind = bsl_pkg::KIND_ELSE;
      end else begin
         ident_kind = bsl_pkg::KIND_IDENT;
      end
      has_pending = 1'b1;
      case (mode_ff)
         MODE_SLASH:  flush_kind = bsl_pkg::KIND_DIV;
         MODE_EQ1:    flush_kind = bsl_pkg::KIND_ASSIGN;
         MODE_NUMBER: flush_kind = bsl_pkg::KIND_NUMBER;
         MODE_IDENT:  flush_kind = ident_kind;
         default: begin
            flush_kind  = bsl_pkg::KIND_EOF;
            has_pending = 1'b0;
         end
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      off_in    = off_ff;
      pbl_in    = pbl_ff;
      pbc_in    = pbc_ff;
      pbo_in    = pbo_ff;
      plen_in   = plen_ff;
      prefix_in = prefix_ff;
      r0_valid  = 1'b0;
      r0_kind   = flush_kind;
      r1_valid  = 1'b0;
      r1_kind   = bsl_pkg::KIND_EOF;
      r1_bl     = line_ff;
      r1_bc     = col_ff;
      r1_el     = line_ff;
      r1_ec     = col_ff;
      r1_off    = off_ff;
      r1_len    = '0;
      do_idle   = 1'b0;
      if (accept) begin
         if (is_end) begin
            r0_valid = has_pending;
            r1_valid = 1'b1;
            mode_in  = MODE_IDLE;
            line_in  = LINE_BITS'(1);
            col_in   = COLUMN_BITS'(1);
            off_in   = '0;
            plen_in  = '0;
         end else begin
            case (mode_ff)
               MODE_ERRORED: begin
               end
               MODE_COMMENT: begin
                  line_in = adv_line;
                  col_in  = adv_col;
                  off_in  = adv_off;
                  if (b == bsl_pkg::CHAR_LF) begin
                     mode_in = MODE_IDLE;
                  end
               end
               MODE_SLASH: begin
                  if (b == bsl_pkg::CHAR_SLASH) begin
                     line_in = adv_line;
                     col_in  = adv_col;
                     off_in  = adv_off;
                     mode_in = MODE_COMMENT;
                  end else begin
                     r0_valid = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               MODE_EQ1: begin
                  if (b == bsl_pkg::CHAR_EQUAL) begin
                     line_in  = adv_line;
                     col_in   = adv_col;
                     off_in   = adv_off;
                     plen_in  = len_plus;
                     r1_valid = 1'b1;
                     r1_kind  = bsl_pkg::KIND_EQ;
                     r1_bl    = pbl_ff;
                     r1_bc    = pbc_ff;
                     r1_off   = pbo_ff;
                     r1_el    = adv_line;
                     r1_ec    = adv_col;
                     r1_len   = len_plus;
                     mode_in  = MODE_IDLE;
                  end else begin
                     r0_valid = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit) begin
                     line_in = adv_line;
                     col_in  = adv_col;
                     off_in  = adv_off;
                     plen_in = len_plus;
                  end else begin
                     r0_valid = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               MODE_IDENT: begin
                  if (is_identc) begin
                     if (plen_ff < LENGTH_BITS'(4)) begin
                        prefix_in = {prefix_ff[23:0], b};
                     end
                     line_in = adv_line;
                     col_in  = adv_col;
                     off_in  = adv_off;
                     plen_in = len_plus;
                  end else begin
                     r0_valid = 1'b1;
                     do_idle  = 1'b1;
                  end
               end
               default: begin
                  do_idle = 1'b1;
               end
            endcase
            if (do_idle) begin
               mode_in = MODE_IDLE;
               if (is_ws) begin
                  line_in = adv_line;
                  col_in  = adv_col;
                  off_in  = adv_off;
               end else if (one_kind != bsl_pkg::KIND_EOF) begin
                  r1_valid = 1'b1;
                  r1_kind  = one_kind;
                  r1_el    = adv_line;
                  r1_ec    = adv_col;
                  r1_len   = LENGTH_BITS'(1);
                  line_in  = adv_line;
                  col_in   = adv_col;
                  off_in   = adv_off;
               end else if ((b == bsl_pkg::CHAR_SLASH) || (b == bsl_pkg::CHAR_EQUAL) ||
                            is_digit || is_letter) begin
                  if (b == bsl_pkg::CHAR_SLASH) begin
                     mode_in = MODE_SLASH;
                  end else if (b == bsl_pkg::CHAR_EQUAL) begin
                     mode_in = MODE_EQ1;
                  end else if (is_digit) begin
                     mode_in = MODE_NUMBER;
                  end else begin
                     mode_in   = MODE_IDENT;
                     prefix_in = {24'd0, b};
                  end
                  pbl_in  = line_ff;
                  pbc_in  = col_ff;
                  pbo_in  = off_ff;
                  plen_in = LENGTH_BITS'(1);
                  line_in = adv_line;
                  col_in  = adv_col;
                  off_in  = adv_off;
               end else begin
                  r1_valid = 1'b1;
                  r1_kind  = bsl_pkg::KIND_ERROR;
                  mode_in  = MODE_ERRORED;
               end
            end
         end
      end
   end

   // flushed token ends at the current position
   assign r0_bits = {plen_ff, pbo_ff, col_ff, line_ff, pbc_ff, pbl_ff};
   assign r1_bits = {r1_len, r1_off, r1_ec, r1_el, r1_bc, r1_bl};

   always_comb begin
      if (r0_valid) begin
         p0_valid = 1'b1;
         p0_data  = {!r1_valid, r0_kind, r0_bits};
         p1_valid = r1_valid;
         p1_data  = {1'b1, r1_kind, r1_bits};
      end else begin
         p0_valid = r1_valid;
         p0_data  = {1'b1, r1_kind, r1_bits};
         p1_valid = 1'b0;
         p1_data  = {1'b1, r1_kind, r1_bits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LINE_BITS'(1);
         col_ff  <= COLUMN_BITS'(1);
         off_ff  <= '0;
         plen_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         off_ff  <= off_in;
         plen_ff <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      pbl_ff    <= pbl_in;
      pbc_ff    <= pbc_in;
      pbo_ff    <= pbo_in;
      prefix_ff <= prefix_in;
   end

   bsl_result_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push0_valid(p0_valid),
      .push0_data (p0_data),
      .push1_valid(p1_valid),
      .push1_data (p1_data),
      .room_two   (req_tready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (q_data)
   );

   assign rsp_tdata = RSP_DATA_W'(q_data[RSP_BITS-1:0]);
   assign rsp_tuser = q_data[RSP_BITS +: KB];
   assign rsp_tlast = q_data[ENTRY_W-1];

   a_end_resets : assert property (@(posedge clock) disable iff (reset)
      accept && is_end |=> mode_ff == MODE_IDLE && line_ff == LINE_BITS'(1) &&
                           col_ff == COLUMN_BITS'(1) && off_ff == '0)
      else $error("end of buffer did not return scanner to start");

   a_end_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      accept && is_end |=> rsp_tvalid)
      else $error("end of buffer produced no token");

   a_error_freezes : assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ERRORED && !(accept && is_end) |=>
         $stable(off_ff) && mode_ff == MODE_ERRORED)
      else $error("position moved after an illegal byte");

endmodule
